// ===== hdl/rcfd_pkg.sv =====
// Shared types and constants for the remote-control receiver frame decoder.
package rcfd_pkg;

    localparam int DECODE_BYTES = 18;
    localparam int STICK_W      = 11;
    localparam int CHAN_W       = 12;
    localparam int AXIS_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;

    localparam logic [STICK_W-1:0] RST_STICK_RAW_MIN = 11'd364;
    localparam logic [STICK_W-1:0] RST_STICK_RAW_MAX = 11'd1684;
    localparam logic [STICK_W-1:0] RST_STICK_CENTER  = 11'd1024;
    localparam logic [STICK_W-1:0] RST_OFFLINE_SPAN  = 11'd660;
    localparam logic [7:0]         RST_LOST_LIMIT    = 8'd20;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_IDLE = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_RANGE_ERR    = 3'd1,
        STAT_LENGTH_ERR   = 3'd2,
        STAT_TICK_ONLINE  = 3'd3,
        STAT_TICK_OFFLINE = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_STICK_RAW_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_RAW_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_SPAN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYBOARD_LINK = 3'd5;

    typedef struct packed {
        logic [STICK_W-1:0] stick_raw_min;
        logic [STICK_W-1:0] stick_raw_max;
        logic [STICK_W-1:0] stick_center;
        logic [STICK_W-1:0] offline_span;
        logic [7:0]         lost_limit;
        logic               keyboard_other_link;
    } cfg_t;

    typedef struct packed {
        logic                   range_ok;
        logic [3:0]             switches;
        logic [4:0][CHAN_W-1:0] sticks;
        logic [2:0][AXIS_W-1:0] mouse;
        logic [15:0]            buttons;
        logic [15:0]            keys;
    } frame_t;

    typedef struct packed {
        status_t                status;
        logic [4:0][CHAN_W-1:0] sticks;
        logic [2:0][AXIS_W-1:0] mouse;
        logic [15:0]            buttons;
        logic [15:0]            keys;
        logic [3:0]             switches;
    } result_t;

endpackage

// ===== hdl/rcfd_frame_buf.sv =====
// Byte collector: frame byte storage and byte counter.
module rcfd_frame_buf #(
    parameter int FRAME_LEN = 18
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   byte_en,
    input  logic [7:0]                             data_byte,
    input  logic                                   clear,
    output logic                                   count_zero,
    output logic                                   count_full,
    output logic [rcfd_pkg::DECODE_BYTES-1:0][7:0] frame
);
    import rcfd_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN + 2);
    localparam int IDX_W = $clog2(DECODE_BYTES);

    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic [DECODE_BYTES-1:0][7:0]    frame_reg;

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (byte_en && (count_reg <= CNT_W'(FRAME_LEN)))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en && (count_reg < CNT_W'(DECODE_BYTES)))
        begin
            frame_reg[count_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CNT_W'(FRAME_LEN));
    assign frame      = frame_reg;

endmodule

// ===== hdl/rcfd_decode.sv =====
// Field extraction, stick range check and re-centering of a full frame.
module rcfd_decode (
    input  logic [rcfd_pkg::DECODE_BYTES-1:0][7:0] frame,
    input  rcfd_pkg::cfg_t                         cfg,
    output rcfd_pkg::frame_t                       dec
);
    import rcfd_pkg::*;

    logic [4:0][STICK_W-1:0] raw;
    logic [3:0]              in_range;

    always_comb
    begin
        raw[0] = {frame[1][2:0], frame[0]};
        raw[1] = {frame[2][5:0], frame[1][7:3]};
        raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
        raw[3] = {frame[5][3:0], frame[4][7:1]};
        raw[4] = {frame[17][2:0], frame[16]};

        for (int k = 0; k < 4; k++)
        begin
            in_range[k] = (raw[k] <= cfg.stick_raw_max) && (raw[k] >= cfg.stick_raw_min);
        end

        dec.range_ok = &in_range;
        dec.switches = frame[5][7:4];
        for (int k = 0; k < 5; k++)
        begin
            dec.sticks[k] = {1'b0, raw[k]} - {1'b0, cfg.stick_center};
        end
        for (int k = 0; k < 3; k++)
        begin
            dec.mouse[k] = {frame[7 + 2 * k], frame[6 + 2 * k]};
        end
        dec.buttons = {frame[13], frame[12]};
        dec.keys    = {frame[15], frame[14]};
    end

endmodule

// ===== hdl/rcfd_out_queue.sv =====
// Two-entry result queue: output register plus skid register.
module rcfd_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rcfd_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output rcfd_pkg::result_t out_data
);
    import rcfd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (push)
                begin
                    skid_data_reg <= push_data;
                end
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/rc_receiver_frame_decoder.sv =====
// Top level of the remote-control receiver frame decoder.
//
// Input channel (in_valid/in_ready) carries one word per accept: a command
// and a data byte. Command byte stores the byte in the frame buffer and
// gives no result. Command idle ends a frame: with no bytes collected it
// gives nothing, otherwise one result with status ok, range error or length
// error. Command tick ages the lost counter and gives one result, online or
// offline. Every result carries the held channel, mouse, key and switch
// values after the word's update.
// Latency: a result is on out_valid the cycle after its word is accepted
// when no older result is waiting in the queue.
// Throughput: one word per cycle while in_ready is high; the state update is a single pass of
// field extraction and compare logic between state and result registers.
// A two-entry result queue lets words keep flowing while the receiver
// stalls; in_ready drops only when both entries hold unread results.
// Reset clears the byte count, all held values and the queue, loads the
// registers with their defaults and sets the lost counter to its limit.
// Configuration writes (cfg_write) take effect at the next edge.
module rc_receiver_frame_decoder #(
    parameter int FRAME_LEN = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          status,
    output logic signed [rcfd_pkg::CHAN_W-1:0]  stick0,
    output logic signed [rcfd_pkg::CHAN_W-1:0]  stick1,
    output logic signed [rcfd_pkg::CHAN_W-1:0]  stick2,
    output logic signed [rcfd_pkg::CHAN_W-1:0]  stick3,
    output logic signed [rcfd_pkg::CHAN_W-1:0]  wheel,
    output logic signed [rcfd_pkg::AXIS_W-1:0]  mouse_x,
    output logic signed [rcfd_pkg::AXIS_W-1:0]  mouse_y,
    output logic signed [rcfd_pkg::AXIS_W-1:0]  mouse_z,
    output logic [15:0]                         mouse_buttons,
    output logic [15:0]                         key_bits,
    output logic [3:0]                          switches
);
    import rcfd_pkg::*;

    cfg_t                   cfg_reg;
    logic [4:0][CHAN_W-1:0] sticks_reg;
    logic [4:0][CHAN_W-1:0] sticks_next;
    logic [2:0][AXIS_W-1:0] mouse_reg;
    logic [2:0][AXIS_W-1:0] mouse_next;
    logic [15:0]            buttons_reg;
    logic [15:0]            buttons_next;
    logic [15:0]            keys_reg;
    logic [15:0]            keys_next;
    logic [3:0]             switches_reg;
    logic [3:0]             switches_next;
    logic [7:0]             lost_reg;
    logic [7:0]             lost_next;

    logic                         accept;
    logic                         byte_en;
    logic                         idle_en;
    logic                         count_zero;
    logic                         count_full;
    logic [DECODE_BYTES-1:0][7:0] frame;
    frame_t                       dec;
    logic                         push;
    status_t                      res_status;
    result_t                      push_data;
    result_t                      out_data;
    logic                         can_push;
    logic [7:0]                   lost_inc;
    logic [3:0]                   near;
    logic signed [CHAN_W:0]       span_pos;
    logic signed [CHAN_W:0]       span_neg;
    logic signed [CHAN_W:0]       stick_ext;

    assign in_ready = can_push;
    assign accept   = in_valid && can_push;
    assign byte_en  = accept && (command == CMD_BYTE);
    assign idle_en  = accept && (command == CMD_IDLE);

    rcfd_frame_buf #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .data_byte  (data_byte),
        .clear      (idle_en),
        .count_zero (count_zero),
        .count_full (count_full),
        .frame      (frame)
    );

    rcfd_decode u_decode (
        .frame (frame),
        .cfg   (cfg_reg),
        .dec   (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_raw_min       <= RST_STICK_RAW_MIN;
            cfg_reg.stick_raw_max       <= RST_STICK_RAW_MAX;
            cfg_reg.stick_center        <= RST_STICK_CENTER;
            cfg_reg.offline_span        <= RST_OFFLINE_SPAN;
            cfg_reg.lost_limit          <= RST_LOST_LIMIT;
            cfg_reg.keyboard_other_link <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STICK_RAW_MIN: cfg_reg.stick_raw_min       <= cfg_data;
                CFG_STICK_RAW_MAX: cfg_reg.stick_raw_max       <= cfg_data;
                CFG_STICK_CENTER:  cfg_reg.stick_center        <= cfg_data;
                CFG_OFFLINE_SPAN:  cfg_reg.offline_span        <= cfg_data;
                CFG_LOST_LIMIT:    cfg_reg.lost_limit          <= cfg_data[7:0];
                CFG_KEYBOARD_LINK: cfg_reg.keyboard_other_link <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lost_inc = (lost_reg < cfg_reg.lost_limit) ? lost_reg + 8'd1 : lost_reg;
        span_pos = {2'b00, cfg_reg.offline_span};
        span_neg = -span_pos;
        for (int k = 0; k < 4; k++)
        begin
            stick_ext = {sticks_reg[k][CHAN_W-1], sticks_reg[k]};
            near[k]   = (stick_ext <= span_pos) && (stick_ext >= span_neg);
        end
    end

    always_comb
    begin
        sticks_next   = sticks_reg;
        mouse_next    = mouse_reg;
        buttons_next  = buttons_reg;
        keys_next     = keys_reg;
        switches_next = switches_reg;
        lost_next     = lost_reg;
        push          = 1'b0;
        res_status    = STAT_OK;
        if (accept)
        begin
            case (command)
                CMD_IDLE:
                begin
                    if (!count_zero)
                    begin
                        push = 1'b1;
                        if (!count_full)
                        begin
                            res_status = STAT_LENGTH_ERR;
                        end
                        else
                        begin
                            switches_next = dec.switches;
                            if (cfg_reg.keyboard_other_link)
                            begin
                                lost_next = '0;
                            end
                            else if (dec.range_ok)
                            begin
                                sticks_next  = dec.sticks;
                                mouse_next   = dec.mouse;
                                buttons_next = dec.buttons;
                                keys_next    = dec.keys;
                                lost_next    = '0;
                            end
                            else
                            begin
                                res_status = STAT_RANGE_ERR;
                                lost_next  = cfg_reg.lost_limit;
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    push      = 1'b1;
                    lost_next = lost_inc;
                    if ((lost_inc >= cfg_reg.lost_limit) && (&near))
                    begin
                        switches_next = '0;
                        res_status    = STAT_TICK_OFFLINE;
                    end
                    else
                    begin
                        res_status = STAT_TICK_ONLINE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticks_reg   <= '0;
            mouse_reg    <= '0;
            buttons_reg  <= '0;
            keys_reg     <= '0;
            switches_reg <= '0;
            lost_reg     <= RST_LOST_LIMIT;
        end
        else
        begin
            sticks_reg   <= sticks_next;
            mouse_reg    <= mouse_next;
            buttons_reg  <= buttons_next;
            keys_reg     <= keys_next;
            switches_reg <= switches_next;
            lost_reg     <= lost_next;
        end
    end

    always_comb
    begin
        push_data.status   = res_status;
        push_data.sticks   = sticks_next;
        push_data.mouse    = mouse_next;
        push_data.buttons  = buttons_next;
        push_data.keys     = keys_next;
        push_data.switches = switches_next;
    end

    rcfd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign status        = out_data.status;
    assign stick0        = out_data.sticks[0];
    assign stick1        = out_data.sticks[1];
    assign stick2        = out_data.sticks[2];
    assign stick3        = out_data.sticks[3];
    assign wheel         = out_data.sticks[4];
    assign mouse_x       = out_data.mouse[0];
    assign mouse_y       = out_data.mouse[1];
    assign mouse_z       = out_data.mouse[2];
    assign mouse_buttons = out_data.buttons;
    assign key_bits      = out_data.keys;
    assign switches      = out_data.switches;

endmodule

// ===== hdl/rcfd_checker.sv =====
// Port-level checker for the frame decoder and its bind.
module rcfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [3:0] switches
);
    import rcfd_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result word dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready && (command == CMD_BYTE) |=> !out_valid)
        else $error("data byte word produced a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready && (command == CMD_TICK) |=>
            out_valid && ((status == STAT_TICK_ONLINE) || (status == STAT_TICK_OFFLINE)))
        else $error("tick word did not give a tick result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_TICK_OFFLINE) |-> (switches == 4'd0))
        else $error("offline result with switches set");

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .switches  (switches)
);

// ===== tb/sv/tb_rc_receiver_frame_decoder.sv =====
// Testbench for rc_receiver_frame_decoder: frame predictor, port driving and result checks.
`timescale 1ns / 1ps

module tb_rc_receiver_frame_decoder;

    import rcfd_pkg::*;

    localparam int FRAME_BYTES = DECODE_BYTES;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    class rc_frame_scoreboard;
        cfg_t regs;
        logic [7:0] frame [FRAME_BYTES];
        int byte_cnt;
        int lost_cnt;
        logic signed [CHAN_W-1:0] chan [5];
        logic [AXIS_W-1:0] mouse [3];
        logic [15:0] buttons;
        logic [15:0] keys;
        logic [1:0] sw_left;
        logic [1:0] sw_right;
        result_t awaited [$];
        int errors;

        function new();
            regs = '{RST_STICK_RAW_MIN, RST_STICK_RAW_MAX, RST_STICK_CENTER,
                     RST_OFFLINE_SPAN, RST_LOST_LIMIT, 1'b0};
            byte_cnt = 0;
            lost_cnt = int'(RST_LOST_LIMIT);
            foreach (chan[k])
                chan[k] = '0;
            foreach (mouse[k])
                mouse[k] = '0;
            buttons = '0;
            keys = '0;
            sw_left = '0;
            sw_right = '0;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_STICK_RAW_MIN: regs.stick_raw_min = val;
                CFG_STICK_RAW_MAX: regs.stick_raw_max = val;
                CFG_STICK_CENTER:  regs.stick_center = val;
                CFG_OFFLINE_SPAN:  regs.offline_span = val;
                CFG_LOST_LIMIT:    regs.lost_limit = val[7:0];
                CFG_KEYBOARD_LINK: regs.keyboard_other_link = val[0];
                default: ;
            endcase
        endfunction

        function status_t decode_frame();
            logic [STICK_W-1:0] raw [5];
            sw_left = frame[5][7:6];
            sw_right = frame[5][5:4];
            if (regs.keyboard_other_link)
                return STAT_OK;
            raw[0] = {frame[1][2:0], frame[0]};
            raw[1] = {frame[2][5:0], frame[1][7:3]};
            raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
            raw[3] = {frame[5][3:0], frame[4][7:1]};
            raw[4] = {frame[17][2:0], frame[16]};
            for (int k = 0; k < 4; k++)
                if (raw[k] > regs.stick_raw_max || raw[k] < regs.stick_raw_min)
                    return STAT_RANGE_ERR;
            for (int k = 0; k < 5; k++)
                chan[k] = {1'b0, raw[k]} - {1'b0, regs.stick_center};
            for (int k = 0; k < 3; k++)
                mouse[k] = {frame[7 + 2 * k], frame[6 + 2 * k]};
            buttons = {frame[13], frame[12]};
            keys = {frame[15], frame[14]};
            return STAT_OK;
        endfunction

        function bit near_centre();
            int span;
            span = int'(regs.offline_span);
            for (int k = 0; k < 4; k++)
                if (int'(chan[k]) > span || int'(chan[k]) < -span)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_word(logic [1:0] cmd, logic [7:0] data);
            status_t st;
            result_t rep;
            if (cmd == CMD_BYTE)
            begin
                if (byte_cnt < FRAME_BYTES)
                    frame[byte_cnt] = data;
                if (byte_cnt <= FRAME_BYTES)
                    byte_cnt++;
                return;
            end
            if (cmd == CMD_IDLE)
            begin
                if (byte_cnt == 0)
                    return;
                if (byte_cnt == FRAME_BYTES)
                begin
                    st = decode_frame();
                    lost_cnt = (st == STAT_OK) ? 0 : int'(regs.lost_limit);
                end
                else
                    st = STAT_LENGTH_ERR;
                byte_cnt = 0;
            end
            else if (cmd == CMD_TICK)
            begin
                if (lost_cnt < int'(regs.lost_limit))
                    lost_cnt++;
                if (lost_cnt >= int'(regs.lost_limit) && near_centre())
                begin
                    sw_left = '0;
                    sw_right = '0;
                    st = STAT_TICK_OFFLINE;
                end
                else
                    st = STAT_TICK_ONLINE;
            end
            else
                return;
            rep.status = st;
            for (int k = 0; k < 5; k++)
                rep.sticks[k] = chan[k];
            for (int k = 0; k < 3; k++)
                rep.mouse[k] = mouse[k];
            rep.buttons = buttons;
            rep.keys = keys;
            rep.switches = {sw_left, sw_right};
            awaited.push_back(rep);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_report(result_t seen);
            result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing pending, status expected none, got %0d",
                         $time, seen.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 16'(want.status), 16'(seen.status));
            for (int k = 0; k < 5; k++)
                compare_field($sformatf("channel %0d", k), 16'(want.sticks[k]),
                              16'(seen.sticks[k]));
            for (int k = 0; k < 3; k++)
                compare_field($sformatf("mouse axis %0d", k), want.mouse[k], seen.mouse[k]);
            compare_field("mouse_buttons", want.buttons, seen.buttons);
            compare_field("key_bits", want.keys, seen.keys);
            compare_field("switches", 16'(want.switches), 16'(seen.switches));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = CMD_BYTE;
    logic [7:0] data_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic signed [CHAN_W-1:0] stick0;
    logic signed [CHAN_W-1:0] stick1;
    logic signed [CHAN_W-1:0] stick2;
    logic signed [CHAN_W-1:0] stick3;
    logic signed [CHAN_W-1:0] wheel;
    logic signed [AXIS_W-1:0] mouse_x;
    logic signed [AXIS_W-1:0] mouse_y;
    logic signed [AXIS_W-1:0] mouse_z;
    logic [15:0] mouse_buttons;
    logic [15:0] key_bits;
    logic [3:0] switches;

    rc_frame_scoreboard sb;
    int idle_cycles = 0;
    int words_sent = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    rc_receiver_frame_decoder #(.FRAME_LEN(FRAME_BYTES)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .stick0(stick0),
        .stick1(stick1),
        .stick2(stick2),
        .stick3(stick3),
        .wheel(wheel),
        .mouse_x(mouse_x),
        .mouse_y(mouse_y),
        .mouse_z(mouse_z),
        .mouse_buttons(mouse_buttons),
        .key_bits(key_bits),
        .switches(switches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin : watch_ports
        result_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.status = status_t'(status);
                seen.sticks[0] = stick0;
                seen.sticks[1] = stick1;
                seen.sticks[2] = stick2;
                seen.sticks[3] = stick3;
                seen.sticks[4] = wheel;
                seen.mouse[0] = mouse_x;
                seen.mouse[1] = mouse_y;
                seen.mouse[2] = mouse_z;
                seen.buttons = mouse_buttons;
                seen.keys = key_bits;
                seen.switches = switches;
                sb.check_report(seen);
            end
            if (in_valid && in_ready)
                sb.note_word(command, data_byte);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Draw a raw stick value: in range for clean frames (when min <= max), edges and outliers otherwise.
    function automatic logic [STICK_W-1:0] pick_raw(bit clean);
        int lo;
        int hi;
        int v;
        int r;
        lo = int'(sb.regs.stick_raw_min);
        hi = int'(sb.regs.stick_raw_max);
        r = $urandom_range(0, 99);
        if (clean && lo <= hi)
        begin
            if (r < 30)
                v = int'(sb.regs.stick_center) + int'($urandom_range(0, 40)) - 20;
            else if (r < 45)
                v = (r % 2 == 1) ? lo : hi;
            else
                v = $urandom_range(hi, lo);
            if (v < lo)
                v = lo;
            if (v > hi)
                v = hi;
        end
        else
        begin
            if (r < 40)
                v = $urandom_range(0, 2047);
            else if (r < 70)
                v = (r % 2 == 1) ? lo - 1 : hi + 1;
            else
                v = (r % 2 == 1) ? lo : hi;
            if (v < 0)
                v = 0;
            if (v > 2047)
                v = 2047;
        end
        return v[STICK_W-1:0];
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [7:0] data);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            words_sent++;
    endtask

    // Pack the sticks into the frame layout, fill the rest at random, close with an idle.
    task automatic send_frame(int len, logic [STICK_W-1:0] r0, logic [STICK_W-1:0] r1,
                              logic [STICK_W-1:0] r2, logic [STICK_W-1:0] r3,
                              logic [STICK_W-1:0] r4);
        logic [7:0] payload [24];
        foreach (payload[i])
            payload[i] = 8'($urandom_range(0, 255));
        payload[0] = r0[7:0];
        payload[1] = {r1[4:0], r0[10:8]};
        payload[2] = {r2[1:0], r1[10:5]};
        payload[3] = r2[9:2];
        payload[4] = {r3[6:0], r2[10]};
        payload[5][3:0] = r3[10:7];
        payload[16] = r4[7:0];
        payload[17][2:0] = r4[10:8];
        for (int i = 0; i < len; i++)
            send_word(CMD_BYTE, payload[i]);
        send_word(CMD_IDLE, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_reports(int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apply_settings(cfg_t s);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_STICK_RAW_MIN, CFG_STICK_RAW_MAX, CFG_STICK_CENTER,
                CFG_OFFLINE_SPAN, CFG_LOST_LIMIT, CFG_KEYBOARD_LINK};
        val = '{s.stick_raw_min, s.stick_raw_max, s.stick_center, s.offline_span,
                CFG_DATA_W'(s.lost_limit), CFG_DATA_W'(s.keyboard_other_link)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(cfg_t s, int words, bit steady);
        int start;
        int seqs;
        int r;
        bit clean;
        drain_reports(SETTLE_CYCLES);
        apply_settings(s);
        tx_steady = steady || ($urandom_range(0, 4) == 0);
        rx_steady = steady || ($urandom_range(0, 4) == 0);
        start = words_sent;
        seqs = 0;
        while (words_sent - start < words || seqs < 12)
        begin
            r = $urandom_range(0, 99);
            clean = ($urandom_range(0, 99) < 65);
            if (r < 65)
                send_frame(FRAME_BYTES, pick_raw(clean), pick_raw(clean), pick_raw(clean),
                           pick_raw(clean), 11'($urandom_range(0, 2047)));
            else if (r < 75)
                send_frame($urandom_range(0, 1) ? $urandom_range(1, 17) : $urandom_range(19, 23),
                           pick_raw(1'b0), pick_raw(1'b0), pick_raw(1'b0), pick_raw(1'b0),
                           11'($urandom_range(0, 2047)));
            else if (r < 93)
                repeat ($urandom_range(1, 4)) send_word(CMD_TICK, 8'($urandom_range(0, 255)));
            else if (r < 97)
                send_word(CMD_IDLE, 8'($urandom_range(0, 255)));
            else
                send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
            seqs++;
            if ($urandom_range(0, 24) == 0)
                drain_reports(0);
        end
    endtask

    task automatic run_stimulus();
        cfg_t s;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_IDLE, 8'hFF);
        send_word(CMD_UNUSED, 8'hA5);
        send_frame(1, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
        send_frame(FRAME_BYTES, 11'd364, 11'd1684, 11'd1024, 11'd364, 11'd2047);
        send_word(CMD_TICK, 8'hFF);

        run_phase('{11'd364, 11'd1684, 11'd1024, 11'd660, 8'd20, 1'b0}, 70, 1'b1);
        run_phase('{11'd0, 11'd2047, 11'd0, 11'd2047, 8'd1, 1'b0}, 70, 1'b0);
        run_phase('{11'd1000, 11'd1100, 11'd2047, 11'd0, 8'd255, 1'b0}, 70, 1'b0);
        run_phase('{11'd200, 11'd1800, 11'd1024, 11'd660, 8'd3, 1'b1}, 70, 1'b0);
        run_phase('{11'd2047, 11'd0, 11'd1024, 11'd660, 8'd2, 1'b0}, 50, 1'b0);
        s.stick_raw_min = 11'($urandom_range(0, 1023));
        s.stick_raw_max = 11'($urandom_range(1024, 2047));
        s.stick_center = 11'($urandom_range(0, 2047));
        s.offline_span = 11'($urandom_range(0, 2047));
        s.lost_limit = 8'($urandom_range(1, 255));
        s.keyboard_other_link = ($urandom_range(0, 3) == 0);
        run_phase(s, 70, 1'b0);
        run_phase('{11'd364, 11'd1684, 11'd1024, 11'd660, 8'd4, 1'b0}, 70, 1'b0);
        drain_reports(2 * SETTLE_CYCLES);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rx_steady)
                out_ready <= 1'b1;
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap(1'b0);
            end
        end
    end

    initial
    begin
        sb = new();
        fork
            run_stimulus();
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any
        if (idle_cycles >= WATCHDOG_LIMIT)
            $display("simulation failed");
        else if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rcfd_pkg.sv
hdl/rcfd_frame_buf.sv
hdl/rcfd_decode.sv
hdl/rcfd_out_queue.sv
hdl/rc_receiver_frame_decoder.sv
hdl/rcfd_checker.sv
tb/sv/tb_rc_receiver_frame_decoder.sv
